// ===== hdl/qfrm_pkg.sv =====
// ---------------------------------------------------------------------------
// qfrm_pkg
// shared widths, stage records and step functions of the rotation matrix
// to quaternion core
// ---------------------------------------------------------------------------
package qfrm_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;
	localparam int AW         = DATA_WIDTH + 1;           // clamped radicand
	localparam int PW         = DATA_WIDTH + 1;           // pair term
	localparam int RW         = DATA_WIDTH;               // square root
	localparam int VW         = 2 * RW;                   // sqrt operand
	localparam int REMW       = RW + 2;                   // sqrt remainder
	localparam int NW         = PW + FRAC_BITS;           // divide numerator
	localparam int DW         = RW + 1;                   // divisor 2r
	localparam int QW         = DATA_WIDTH - 1;           // quotient bits
	localparam int SQ_STEPS   = RW;
	localparam int DV_STEPS   = QW + 1;                   // overflow + bits
	localparam int STEPS_PER_STAGE = 2;
	localparam int SQ_STAGES  = SQ_STEPS / STEPS_PER_STAGE;
	localparam int DV_STAGES  = DV_STEPS / STEPS_PER_STAGE;

	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	localparam logic [DATA_WIDTH-1:0] SAT_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] SAT_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic [1:0]          br;
		logic [3:0][PW-1:0]  p;
		logic [VW-1:0]       v;
		logic [REMW-1:0]     rem;
		logic [RW-1:0]       root;
	} sq_t;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [QW-1:0] q;
		logic          ovf;
		logic          neg;
	} cmp_t;

	typedef struct packed {
		logic [1:0]        br;
		logic [RW-1:0]     root;
		logic              zero;
		logic [DW-1:0]     d;
		cmp_t [3:0]        c;
	} dv_t;

	// one digit of the restoring square root
	function automatic sq_t sq_step(sq_t a);
		logic [REMW+1:0] r4;
		logic [REMW+1:0] tr;
		sq_t b;
		b  = a;
		r4 = {a.rem, a.v[VW-1 -: 2]};
		tr = {2'b00, a.root, 2'b01};
		if (r4 >= tr) begin
			b.rem  = REMW'(r4 - tr);
			b.root = {a.root[RW-2:0], 1'b1};
		end else begin
			b.rem  = r4[REMW-1:0];
			b.root = {a.root[RW-2:0], 1'b0};
		end
		b.v = {a.v[VW-3:0], 2'b00};
		return b;
	endfunction

	// one quotient bit; the top position only flags overflow
	function automatic cmp_t dv_step(cmp_t c, logic [DW-1:0] d, int k);
		logic [NW+1:0] ds;
		cmp_t o;
		o  = c;
		ds = (NW+2)'(d) << k;
		if (k == QW) begin
			o.ovf = ((NW+2)'(c.rem) >= ds);
		end else if (!c.ovf && ((NW+2)'(c.rem) >= ds)) begin
			o.rem = NW'((NW+2)'(c.rem) - ds);
			o.q   = c.q | (QW'(1) << k);
		end
		return o;
	endfunction

endpackage

// ===== hdl/quaternion_from_rotation_matrix_core.sv =====
// ---------------------------------------------------------------------------
// quaternion_from_rotation_matrix_core
// rotation matrix (nine Q2.14 elements) to unit quaternion, Shepperd's rule
// ---------------------------------------------------------------------------
//  channel  | ports                         | handshake
//  ---------+-------------------------------+----------------------------
//  input    | m00 .. m22                    | start & !busy
//  result   | quat_w/x/y/z, branch_taken    | done, one cycle, no stall
//
//  one item enters per clock; busy is never raised
//  the pipeline is 1 select stage, 8 square root stages (two root
//  bits each), 1 divide setup stage, 8 divide stages (two divide
//  steps each, four lanes in parallel) and the output register
//  arst_n clears the stage valid bits only; payload registers are not reset
//  the result is shown for exactly one cycle, the receiver cannot stall
// ---------------------------------------------------------------------------
module quaternion_from_rotation_matrix_core
	import qfrm_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] m00,
	input  logic signed [DATA_WIDTH-1:0] m01,
	input  logic signed [DATA_WIDTH-1:0] m02,
	input  logic signed [DATA_WIDTH-1:0] m10,
	input  logic signed [DATA_WIDTH-1:0] m11,
	input  logic signed [DATA_WIDTH-1:0] m12,
	input  logic signed [DATA_WIDTH-1:0] m20,
	input  logic signed [DATA_WIDTH-1:0] m21,
	input  logic signed [DATA_WIDTH-1:0] m22,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] quat_w,
	output logic signed [DATA_WIDTH-1:0] quat_x,
	output logic signed [DATA_WIDTH-1:0] quat_y,
	output logic signed [DATA_WIDTH-1:0] quat_z,
	output logic [1:0]                   branch_taken
);

	localparam int TW = DATA_WIDTH + 3;   // trace and radicand, signed

	// the pipeline never stalls, so a new item is always welcome
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// ---------------- stage 1: branch select, radicand, pair terms
	logic signed [TW-1:0] tr_c, a_c;
	logic signed [TW-1:0] e00, e11, e22, one_c;
	logic [1:0]           br_c;
	logic [3:0][PW-1:0]   p_c;
	logic signed [PW-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;

	always_comb begin
		e00    = TW'(m00);
		e11    = TW'(m11);
		e22    = TW'(m22);
		one_c  = TW'(1) <<< FRAC_BITS;
		tr_c   = e00 + e11 + e22;
		d21_12 = PW'(m21) - PW'(m12);
		d02_20 = PW'(m02) - PW'(m20);
		d10_01 = PW'(m10) - PW'(m01);
		s01_10 = PW'(m01) + PW'(m10);
		s02_20 = PW'(m02) + PW'(m20);
		s12_21 = PW'(m12) + PW'(m21);
		// the major component's slot carries no pair term
		p_c = '0;
		if (tr_c > 0) begin
			br_c   = BR_TRACE;
			a_c    = tr_c + one_c;
			p_c[1] = d21_12;
			p_c[2] = d02_20;
			p_c[3] = d10_01;
		end else if (m00 > m11 && m00 > m22) begin
			br_c   = BR_X;
			a_c    = one_c + e00 - e11 - e22;
			p_c[0] = d21_12;
			p_c[2] = s01_10;
			p_c[3] = s02_20;
		end else if (m11 > m22) begin
			br_c   = BR_Y;
			a_c    = one_c + e11 - e00 - e22;
			p_c[0] = d02_20;
			p_c[1] = s01_10;
			p_c[3] = s12_21;
		end else begin
			br_c   = BR_Z;
			a_c    = one_c + e22 - e00 - e11;
			p_c[0] = d10_01;
			p_c[1] = s02_20;
			p_c[2] = s12_21;
		end
	end

	logic vld_s1;
	sq_t  prep_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		prep_s1.br   <= br_c;
		prep_s1.p    <= p_c;
		// a negative radicand (not a rotation) is clamped to zero
		prep_s1.v    <= (a_c < 0) ? '0 : VW'({a_c[AW-1:0], {FRAC_BITS{1'b0}}});
		prep_s1.rem  <= '0;
		prep_s1.root <= '0;
	end

	// ---------------- stages 2..9: square root, two digits per stage
	logic [SQ_STAGES-1:0] vld_sq_s;
	sq_t                  sq_s  [SQ_STAGES];
	sq_t                  sq_nx [SQ_STAGES];

	always_comb begin
		for (int j = 0; j < SQ_STAGES; j++) begin
			sq_nx[j] = (j == 0) ? prep_s1 : sq_s[(j == 0) ? 0 : j - 1];
			for (int t = 0; t < STEPS_PER_STAGE; t++) begin
				sq_nx[j] = sq_step(sq_nx[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sq_s <= '0;
		end else begin
			vld_sq_s <= {vld_sq_s[SQ_STAGES-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < SQ_STAGES; j++) begin
			sq_s[j] <= sq_nx[j];
		end
	end

	// ---------------- stage 10: divide setup, numerator = |p|*ONE + r
	sq_t           sq_last;
	dv_t           setup_c;
	logic [PW-1:0] mag_c;
	assign sq_last = sq_s[SQ_STAGES-1];

	always_comb begin
		setup_c            = '0;
		setup_c.br         = sq_last.br;
		setup_c.root       = sq_last.root;
		setup_c.zero       = (sq_last.root == '0);
		setup_c.d          = {sq_last.root, 1'b0};
		mag_c              = '0;
		for (int c = 0; c < 4; c++) begin
			setup_c.c[c].neg = sq_last.p[c][PW-1];
			mag_c            = sq_last.p[c][PW-1] ? PW'(-sq_last.p[c]) : sq_last.p[c];
			setup_c.c[c].rem = {mag_c, {FRAC_BITS{1'b0}}} + NW'(sq_last.root);
		end
	end

	logic vld_s10;
	dv_t  setup_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else begin
			vld_s10 <= vld_sq_s[SQ_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		setup_s10 <= setup_c;
	end

	// ---------------- stages 11..18: four restoring dividers in lockstep
	logic [DV_STAGES-1:0] vld_dv_s;
	dv_t                  dv_s  [DV_STAGES];
	dv_t                  dv_nx [DV_STAGES];

	always_comb begin
		for (int j = 0; j < DV_STAGES; j++) begin
			dv_nx[j] = (j == 0) ? setup_s10 : dv_s[(j == 0) ? 0 : j - 1];
			for (int t = 0; t < STEPS_PER_STAGE; t++) begin
				for (int c = 0; c < 4; c++) begin
					dv_nx[j].c[c] = dv_step(dv_nx[j].c[c], dv_nx[j].d,
						QW - (j * STEPS_PER_STAGE + t));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dv_s <= '0;
		end else begin
			vld_dv_s <= {vld_dv_s[DV_STAGES-2:0], vld_s10};
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < DV_STAGES; j++) begin
			dv_s[j] <= dv_nx[j];
		end
	end

	// ---------------- output: major, rounding, saturation, sign
	dv_t                       dv_last;
	logic [3:0][DATA_WIDTH-1:0] comp_c;
	logic [DATA_WIDTH-1:0]      major_c;
	assign dv_last = dv_s[DV_STAGES-1];

	always_comb begin
		// (r + 1) >> 1 stays far below the positive limit
		major_c = DATA_WIDTH'(({1'b0, dv_last.root} + (RW+1)'(1)) >> 1);
		for (int c = 0; c < 4; c++) begin
			if (2'(c) == dv_last.br) begin
				comp_c[c] = major_c;
			end else if (dv_last.zero) begin
				comp_c[c] = '0;
			end else if (dv_last.c[c].ovf) begin
				comp_c[c] = dv_last.c[c].neg ? SAT_NEG : SAT_POS;
			end else if (dv_last.c[c].neg) begin
				comp_c[c] = DATA_WIDTH'(-{1'b0, dv_last.c[c].q});
			end else begin
				comp_c[c] = {1'b0, dv_last.c[c].q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_dv_s[DV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		quat_w       <= comp_c[0];
		quat_x       <= comp_c[1];
		quat_y       <= comp_c[2];
		quat_z       <= comp_c[3];
		branch_taken <= dv_last.br;
	end

	// ---------------- checks
	logic signed [DATA_WIDTH-1:0] major_out;
	always_comb begin
		case (branch_taken)
			BR_TRACE: major_out = quat_w;
			BR_X:     major_out = quat_x;
			BR_Y:     major_out = quat_y;
			BR_Z:     major_out = quat_z;
			default:  major_out = quat_w;
		endcase
	end

	// the last divide stage always lands on the result strobe
	a_dv_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		vld_dv_s[DV_STAGES-1] |=> done)
		else $error("divide stage did not produce a result");

	// the finished root leaves a remainder no larger than 2r
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sq_s[SQ_STAGES-1] |->
		({1'b0, sq_last.rem} <= (REMW+1)'({sq_last.root, 1'b0})))
		else $error("square root remainder out of range");

	// the major component is a halved root and never negative
	a_major_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !major_out[DATA_WIDTH-1])
		else $error("major component negative");

endmodule
